// ===== sv/log_odds_grid_cell_update_unit_defines.svh =====
// Assertion macros used by the checker of the grid cell unit
`ifndef LOG_ODDS_GRID_CELL_UPDATE_UNIT_DEFINES_SVH
`define LOG_ODDS_GRID_CELL_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LGCU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("grid cell unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LGCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("grid cell unit: next-cycle check failed");

`endif

// ===== sv/lgcu_pkg.sv =====
package lgcu_pkg;

	// width of the configuration registers and their reset value
	localparam int CFG_W = 9;
	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

	// register indexes
	localparam logic CFG_GRID_WIDTH  = 1'b0;
	localparam logic CFG_GRID_HEIGHT = 1'b1;

	// operation codes; the unused code behaves as a read
	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_READ   = 2'd1;
	localparam logic [1:0] FUNC_FILL   = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_MODIFY,
		ST_FILL
	} state_t;

	// which value goes into the output register
	typedef enum logic [1:0] {
		RES_MISS,
		RES_CELL,
		RES_FILL
	} res_src_t;

	typedef struct packed {
		logic     accept;     // capture the input item
		logic     decode;     // register index, fill count, zero the sweep counter
		logic     rd_en;      // read the addressed cell
		logic     modify;     // write back an updated cell
		logic     sweep_we;   // write the cell under the sweep counter
		logic     sweep_zero; // sweep writes zero over the whole store
		logic     load_res;   // load the output register
		res_src_t res_src;
	} cmd_t;

	typedef struct packed {
		logic is_fill;
		logic hit;
		logic sweep_done;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/lgcu_ctrl.sv =====
module lgcu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lgcu_pkg::stat_t stat,
	output lgcu_pkg::cmd_t  cmd
);

	lgcu_pkg::state_t state_q, state_d;

	// state register; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgcu_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lgcu_pkg::ST_CLEAR: begin
				if (stat.sweep_done) state_d = lgcu_pkg::ST_IDLE;
			end
			lgcu_pkg::ST_IDLE: begin
				if (in_valid) state_d = lgcu_pkg::ST_DECODE;
			end
			lgcu_pkg::ST_DECODE: begin
				if (stat.is_fill) begin
					state_d = lgcu_pkg::ST_FILL;
				end else if (stat.hit) begin
					state_d = lgcu_pkg::ST_READ;
				end else if (stat.out_free) begin
					state_d = lgcu_pkg::ST_IDLE;
				end
			end
			lgcu_pkg::ST_READ: begin
				state_d = lgcu_pkg::ST_MODIFY;
			end
			lgcu_pkg::ST_MODIFY: begin
				if (stat.out_free) state_d = lgcu_pkg::ST_IDLE;
			end
			lgcu_pkg::ST_FILL: begin
				if (stat.sweep_done && stat.out_free) state_d = lgcu_pkg::ST_IDLE;
			end
			default: begin
				state_d = lgcu_pkg::ST_IDLE;
			end
		endcase
	end

	// commands to the datapath
	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.res_src    = lgcu_pkg::RES_MISS;
		case (state_q)
			lgcu_pkg::ST_CLEAR: begin
				cmd.sweep_zero = 1'b1;
				cmd.sweep_we   = !stat.sweep_done;
			end
			lgcu_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			lgcu_pkg::ST_DECODE: begin
				cmd.decode = 1'b1;
				// out-of-range read or update answers in this state, once the output register is free
				if (!stat.is_fill && !stat.hit) begin
					cmd.load_res = stat.out_free;
					cmd.res_src  = lgcu_pkg::RES_MISS;
				end
			end
			lgcu_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			lgcu_pkg::ST_MODIFY: begin
				cmd.modify   = stat.out_free;
				cmd.load_res = stat.out_free;
				cmd.res_src  = lgcu_pkg::RES_CELL;
			end
			lgcu_pkg::ST_FILL: begin
				cmd.sweep_we = !stat.sweep_done;
				cmd.load_res = stat.sweep_done && stat.out_free;
				cmd.res_src  = lgcu_pkg::RES_FILL;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/lgcu_dpath.sv =====
module lgcu_dpath #(
	parameter int MAX_COLS  = 256,
	parameter int MAX_ROWS  = 256,
	parameter int CELL_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lgcu_pkg::CFG_W-1:0] cfg_wdata,
	// input item
	input  logic [1:0]                 func,
	input  logic signed [9:0]          cell_col,
	input  logic signed [9:0]          cell_row,
	input  logic signed [7:0]          log_odds_value,
	// result item
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [7:0]          cell_value,
	output logic                       in_range,
	// controller
	input  lgcu_pkg::cmd_t             cmd,
	output lgcu_pkg::stat_t            stat
);

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CB     = CELL_BITS;
	// limits in use never exceed what a register can hold
	localparam int COL_LIM = (MAX_COLS > 511) ? 511 : MAX_COLS;
	localparam int ROW_LIM = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
	localparam logic [8:0] COL_LIM9 = 9'(COL_LIM);
	localparam logic [8:0] ROW_LIM9 = 9'(ROW_LIM);
	localparam logic [CB-1:0] CELL_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] CELL_MIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [8:0]        w_q, h_q;
	logic [1:0]        func_q;
	logic signed [9:0] col_q, row_q;
	logic signed [7:0] val_q;
	logic [ADDR_W-1:0] idx_q;
	logic [CNT_W-1:0]  n_q, cnt_q;
	logic [CB-1:0]     rdata_q;
	logic              out_valid_q, in_range_q;
	logic [7:0]        cell_value_q;

	logic [8:0]        w_use, h_use;
	logic [17:0]       row_off, n_prod;
	logic [18:0]       idx_sum;
	logic              hit_d;
	logic signed [CB:0] rd_w, val_w, sum_w;
	logic [CB-1:0]     upd_cell, fill_cell;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CB-1:0]     mem_wdata;
	logic              out_free;

	logic [CB-1:0] mem [DEPTH];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= lgcu_pkg::CFG_DIM_RESET;
			h_q <= lgcu_pkg::CFG_DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == lgcu_pkg::CFG_GRID_WIDTH) begin
				w_q <= cfg_wdata;
			end else begin
				w_q <= w_q;
			end
			if (cfg_index == lgcu_pkg::CFG_GRID_HEIGHT) begin
				h_q <= cfg_wdata;
			end else begin
				h_q <= h_q;
			end
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			col_q  <= cell_col;
			row_q  <= cell_row;
			val_q  <= log_odds_value;
		end
	end

	// dimensions in use, range check and cell index
	always_comb begin
		w_use   = (w_q > COL_LIM9) ? COL_LIM9 : w_q;
		h_use   = (h_q > ROW_LIM9) ? ROW_LIM9 : h_q;
		hit_d   = !col_q[9] && !row_q[9] && (col_q[8:0] < w_use) && (row_q[8:0] < h_use);
		row_off = 18'(row_q[8:0]) * 18'(w_use);
		n_prod  = 18'(h_use) * 18'(w_use);
		idx_sum = 19'(col_q[8:0]) + 19'(row_off);
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			idx_q <= ADDR_W'(idx_sum);
			n_q   <= CNT_W'(n_prod);
		end
	end

	// sweep counter, shared by the clearing pass and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.decode) begin
			cnt_q <= '0;
		end else if (cmd.sweep_we) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// saturating add of the observation
	always_comb begin
		rd_w  = (CB+1)'(signed'(rdata_q));
		val_w = (CB+1)'(val_q);
		sum_w = rd_w + val_w;
		if (sum_w[CB] != sum_w[CB-1]) begin
			upd_cell = sum_w[CB] ? CELL_MIN : CELL_MAX;
		end else begin
			upd_cell = sum_w[CB-1:0];
		end
		fill_cell = CB'(val_q);
	end

	// single write port: sweep or write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = upd_cell;
		if (cmd.sweep_we) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[ADDR_W-1:0];
			mem_wdata = cmd.sweep_zero ? '0 : fill_cell;
		end else if (cmd.modify && (func_q == lgcu_pkg::FUNC_UPDATE)) begin
			mem_we = 1'b1;
		end
	end

	// cell memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.rd_en) rdata_q <= mem[idx_q];
	end

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			case (cmd.res_src)
				lgcu_pkg::RES_CELL: begin
					cell_value_q <= (cmd.modify && func_q == lgcu_pkg::FUNC_UPDATE) ?
						upd_cell[7:0] : rdata_q[7:0];
					in_range_q   <= 1'b1;
				end
				lgcu_pkg::RES_FILL: begin
					cell_value_q <= val_q;
					in_range_q   <= (n_q != '0);
				end
				default: begin
					cell_value_q <= '0;
					in_range_q   <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;
	assign in_range   = in_range_q;

	// status to the controller
	always_comb begin
		stat.is_fill    = (func_q == lgcu_pkg::FUNC_FILL);
		stat.hit        = hit_d;
		stat.sweep_done = cmd.sweep_zero ? (cnt_q == DEPTH_CNT) : (cnt_q == n_q);
		stat.out_free   = out_free;
	end

endmodule

// ===== sv/log_odds_grid_cell_update_unit.sv =====
// Log-odds occupancy grid: a store of MAX_COLS*MAX_ROWS signed CELL_BITS cells, addressed as
// column + row * width in use, with saturating update, read and fill. After reset the block
// runs a clearing pass over the whole store with in_ready low (configuration writes are taken
// meanwhile). An in-range update or read then steps through capture, index, memory read and
// write-back, and the next item is taken only once it is done; an out-of-range update or read
// is answered from the index step with no memory access; a fill writes one cell per cycle over
// the width*height cells in use. A finished result waits in an output register.
module log_odds_grid_cell_update_unit #(
	parameter int MAX_COLS  = 256,
	parameter int MAX_ROWS  = 256,
	parameter int CELL_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lgcu_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic signed [9:0]          cell_col,
	input  logic signed [9:0]          cell_row,
	input  logic signed [7:0]          log_odds_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [7:0]          cell_value,
	output logic                       in_range
);

	lgcu_pkg::cmd_t  cmd;
	lgcu_pkg::stat_t stat;

	// sequencer
	lgcu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// cell store and arithmetic
	lgcu_dpath #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.CELL_BITS (CELL_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.func           (func),
		.cell_col       (cell_col),
		.cell_row       (cell_row),
		.log_odds_value (log_odds_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cell_value     (cell_value),
		.in_range       (in_range),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

// ===== sv/lgcu_checker.sv =====
`include "log_odds_grid_cell_update_unit_defines.svh"

module lgcu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [7:0] cell_value,
	input logic              in_range
);

	// a stalled result stays offered
	`LGCU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// a stalled result keeps its payload
	`LGCU_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(cell_value) && $stable(in_range))

	// one item at a time: after a transfer in, the input side closes
	`LGCU_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// a new result only appears while an item is being worked on
	`LGCU_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind log_odds_grid_cell_update_unit lgcu_checker u_lgcu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.cell_value (cell_value),
	.in_range   (in_range)
);

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// spare operation code; the block treats it as a read
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int GRID_COLS = 256;
	localparam int GRID_ROWS = 256;
	localparam int FILL_CELLS_MAX = 4096;  // random fills only on grids this small
	localparam int HOLD_CYCLES = 300;
	// clearing pass, three full-size fills, small fills, every result stalled
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int NUM_DIRECTED = 22;
	localparam int NUM_SHAPES = 9;

	typedef struct packed {
		logic [1:0]        op;
		logic signed [9:0] col;
		logic signed [9:0] row;
		logic signed [7:0] obs;
		logic              typed;  // expected result given in the row
		logic signed [7:0] value;
		logic              hit;
	} grid_vector_t;

	typedef struct packed {
		logic signed [7:0] value;
		logic              hit;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = lgcu_pkg::CFG_GRID_WIDTH;
	logic [lgcu_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = lgcu_pkg::FUNC_READ;
	logic signed [9:0] cell_col = '0;
	logic signed [9:0] cell_row = '0;
	logic signed [7:0] log_odds_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [7:0] cell_value;
	logic in_range;

	log_odds_grid_cell_update_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.cell_col(cell_col),
		.cell_row(cell_row),
		.log_odds_value(log_odds_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_value(cell_value),
		.in_range(in_range)
	);

	always #4 clk = ~clk;

	// predictor state: own copy of the cell store and the shape registers
	logic signed [7:0] grid_cells [GRID_COLS*GRID_ROWS];
	int unsigned grid_width_reg = 256;
	int unsigned grid_height_reg = 256;
	cell_result_t cell_results_due [$];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_ask = 0;
	int hold_seen = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int checked_count = 0;
	int fill_count = 0;
	int saturate_count = 0;

	grid_vector_t directed_ops [NUM_DIRECTED] = '{
		'{lgcu_pkg::FUNC_READ,      0,    0,    0, 1,    0, 1},
		'{lgcu_pkg::FUNC_READ,    255,  255,    0, 1,    0, 1},
		'{lgcu_pkg::FUNC_READ,    256,    0,    0, 1,    0, 0},
		'{lgcu_pkg::FUNC_UPDATE,   -1,    0,   50, 1,    0, 0},
		'{lgcu_pkg::FUNC_UPDATE,    0, -512,   50, 1,    0, 0},
		'{lgcu_pkg::FUNC_READ,    511,  511,    0, 1,    0, 0},
		'{lgcu_pkg::FUNC_UPDATE,    0,  256,    9, 1,    0, 0},
		'{lgcu_pkg::FUNC_UPDATE,    3,    4,  127, 1,  127, 1},
		'{lgcu_pkg::FUNC_UPDATE,    3,    4,  127, 1,  127, 1},
		'{lgcu_pkg::FUNC_UPDATE,    3,    4, -128, 1,   -1, 1},
		'{lgcu_pkg::FUNC_UPDATE,    3,    4, -128, 1, -128, 1},
		'{FUNC_SPARE,               3,    4,   99, 1, -128, 1},
		'{lgcu_pkg::FUNC_UPDATE,  255,  255,  -77, 1,  -77, 1},
		'{lgcu_pkg::FUNC_UPDATE,  255,  255,   20, 0,    0, 0},
		'{lgcu_pkg::FUNC_FILL,   -512,  511, -128, 1, -128, 1},
		'{lgcu_pkg::FUNC_READ,    255,  255,    0, 1, -128, 1},
		'{lgcu_pkg::FUNC_UPDATE,  128,   64,   -1, 1, -128, 1},
		'{lgcu_pkg::FUNC_FILL,     -1,   -1,  127, 1,  127, 1},
		'{lgcu_pkg::FUNC_UPDATE,    0,    0,    1, 1,  127, 1},
		'{lgcu_pkg::FUNC_UPDATE,    0,    0, -100, 0,    0, 0},
		'{lgcu_pkg::FUNC_FILL,      7,    9,    0, 1,    0, 1},
		'{lgcu_pkg::FUNC_READ,      3,    4,    0, 1,    0, 1}
	};

	// grid shapes for the random part: register values as written, and item counts
	int shape_w [NUM_SHAPES] = '{0, 511, 1, 5, 16, 256, 3, 170, 37};
	int shape_h [NUM_SHAPES] = '{7, 3, 1, 300, 16, 256, 0, 85, 100};
	int shape_items [NUM_SHAPES] = '{40, 200, 60, 200, 250, 250, 40, 160, 100};

	function automatic int used_width();
		return (grid_width_reg > GRID_COLS) ? GRID_COLS : grid_width_reg;
	endfunction

	function automatic int used_height();
		return (grid_height_reg > GRID_ROWS) ? GRID_ROWS : grid_height_reg;
	endfunction

	// apply one operation to the cell store and return the result it gives
	function automatic cell_result_t apply_cell_op(grid_vector_t v);
		int w;
		int h;
		int c;
		int r;
		int idx;
		int sum;
		cell_result_t res;
		w = used_width();
		h = used_height();
		c = v.col;
		r = v.row;
		res.value = '0;
		res.hit = 1'b0;
		if (v.op == lgcu_pkg::FUNC_FILL) begin
			for (int k = 0; k < w * h; k++)
				grid_cells[k] = v.obs;
			res.value = v.obs;
			res.hit = (w * h != 0);
			fill_count++;
		end else if (c >= 0 && r >= 0 && c < w && r < h) begin
			idx = c + r * w;
			sum = grid_cells[idx];
			if (v.op == lgcu_pkg::FUNC_UPDATE) begin
				sum = sum + v.obs;
				if (sum > 127 || sum < -128)
					saturate_count++;
				sum = (sum > 127) ? 127 : (sum < -128) ? -128 : sum;
				grid_cells[idx] = 8'(sum);
			end
			res.value = 8'(sum);
			res.hit = 1'b1;
		end
		return res;
	endfunction

	// random operation: mostly in-grid cells, some crowding onto a corner to saturate
	function automatic grid_vector_t random_grid_op(bit fills_ok);
		int w;
		int h;
		int pick;
		int hot_w;
		int hot_h;
		grid_vector_t v;
		w = used_width();
		h = used_height();
		v = '0;
		pick = $urandom_range(99);
		if (pick < 55)
			v.op = lgcu_pkg::FUNC_UPDATE;
		else if (pick < 80)
			v.op = lgcu_pkg::FUNC_READ;
		else if (pick < 85)
			v.op = FUNC_SPARE;
		else
			v.op = fills_ok ? lgcu_pkg::FUNC_FILL : lgcu_pkg::FUNC_READ;
		if (w > 0 && h > 0 && $urandom_range(99) < 85) begin
			hot_w = (w < 4) ? w : 4;
			hot_h = (h < 4) ? h : 4;
			if ($urandom_range(99) < 30) begin
				v.col = 10'($urandom_range(hot_w - 1));
				v.row = 10'($urandom_range(hot_h - 1));
			end else begin
				v.col = 10'($urandom_range(w - 1));
				v.row = 10'($urandom_range(h - 1));
			end
		end else begin
			v.col = 10'($urandom);
			v.row = 10'($urandom);
		end
		if ($urandom_range(99) < 20)
			v.obs = $urandom_range(1) ? 8'sd127 : -8'sd128;
		else
			v.obs = 8'($urandom);
		return v;
	endfunction

	// offer one item, with random gaps, and record its result on transfer
	task automatic transfer_cell_op(grid_vector_t v);
		cell_result_t res;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= v.op;
		cell_col <= v.col;
		cell_row <= v.row;
		log_odds_value <= v.obs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = apply_cell_op(v);
		if (v.typed) begin
			res.value = v.value;
			res.hit = v.hit;
		end
		cell_results_due.insert(cell_results_due.size(), res);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (cell_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_grid_shape(int w, int h);
		cfg_we <= 1'b1;
		cfg_index <= lgcu_pkg::CFG_GRID_WIDTH;
		cfg_wdata <= lgcu_pkg::CFG_W'(w);
		@(posedge clk);
		grid_width_reg = w;
		cfg_index <= lgcu_pkg::CFG_GRID_HEIGHT;
		cfg_wdata <= lgcu_pkg::CFG_W'(h);
		@(posedge clk);
		grid_height_reg = h;
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			stall_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// result check on each output transfer
	always @(posedge clk) begin : result_check
		cell_result_t due;
		if (arst_n && out_valid && out_ready) begin
			if (cell_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: value %0d in_range %0b", cell_value, in_range);
			end else begin
				due = cell_results_due.pop_front();
				checked_count++;
				if (cell_value !== due.value || in_range !== due.hit) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected value %0d in_range %0b, got value %0d in_range %0b",
							due.value, due.hit, cell_value, in_range);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < GRID_COLS * GRID_ROWS; k++)
			grid_cells[k] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		snd_idle_pct = 17;
		rcv_idle_pct = 61;

		// directed part on the reset shape; waits out the clearing pass
		foreach (directed_ops[i])
			transfer_cell_op(directed_ops[i]);

		// random part, one grid shape per phase
		for (int p = 0; p < NUM_SHAPES; p++) begin
			if (p == 3) begin
				snd_idle_pct = 61;
				rcv_idle_pct = 17;
			end else if (p == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			drain_results();
			set_grid_shape(shape_w[p], shape_h[p]);
			for (int k = 0; k < shape_items[p]; k++) begin
				// long output hold while items keep coming: back-pressure to the input
				if (p == 4 && k == 0)
					hold_ask <= hold_ask + 1;
				if (p == 3 && k == shape_items[p] / 2)
					drain_results();
				transfer_cell_op(random_grid_op(used_width() * used_height() <= FILL_CELLS_MAX));
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("checked %0d cell results over %0d grid shapes including zero and oversized sizes",
			checked_count, NUM_SHAPES);
		$display("%0d fills and %0d saturating updates seen", fill_count, saturate_count);
		if (mismatch_count == 0 && cell_results_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lgcu_pkg.sv
sv/lgcu_ctrl.sv
sv/lgcu_dpath.sv
sv/log_odds_grid_cell_update_unit.sv
sv/lgcu_checker.sv
bench/testbench.sv
